@@ hdl/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types, constants and mask helpers for the CIDR subnet allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int ADDR_W    = 128;
  localparam int HALF_W    = 64;
  localparam int V4_BITS   = 32;
  localparam int LEN_W     = 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0] V4_WIDTH = LEN_W'(V4_BITS);
  localparam logic [LEN_W-1:0] V6_WIDTH = LEN_W'(ADDR_W);

  localparam logic [CFG_IDX_W-1:0] REG_FAMILY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HI  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LO  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN = CFG_IDX_W'(3);

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] extra_bits;
    logic             last_in_list;
  } csa_in_t;

  typedef struct packed {
    logic [HALF_W-1:0] subnet_addr_hi;
    logic [HALF_W-1:0] subnet_addr_lo;
    logic [LEN_W-1:0]  subnet_prefix_len;
    logic              status;
    logic              end_of_list;
  } csa_out_t;

  typedef struct packed {
    logic              family_is_v6;
    logic [HALF_W-1:0] base_addr_hi;
    logic [HALF_W-1:0] base_addr_lo;
    logic [LEN_W-1:0]  base_prefix_len;
  } csa_cfg_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic              fresh;
    logic              v6;
    logic              err;
    logic              last;
    logic [LEN_W-1:0]  newlen;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] mask;
  } csa_qent_t;

  function automatic logic [ADDR_W-1:0] width_mask(input logic v6);
    width_mask = v6 ? {ADDR_W{1'b1}} : {{(ADDR_W-V4_BITS){1'b0}}, {V4_BITS{1'b1}}};
  endfunction

  // Low k bits set; a shift count of ADDR_W gives all ones.
  function automatic logic [ADDR_W-1:0] low_mask(input logic [LEN_W-1:0] k);
    low_mask = ~({ADDR_W{1'b1}} << k);
  endfunction

endpackage

@@ hdl/csa_front.sv @@
// ----------------------------------------------------------------------------
// csa_front
// Accepts requests, computes the new prefix length, the error flag, the
// alignment mask and the list start address, and pushes them to the queue.
// ----------------------------------------------------------------------------
module csa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  csa_pkg::csa_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  csa_pkg::csa_in_t   in_data,
  output logic               q_push,
  output csa_pkg::csa_qent_t q_data,
  input  logic               q_full
);
  import csa_pkg::*;

  logic             fresh_r;
  logic             fresh_nxt;
  logic [LEN_W-1:0] width;
  logic [LEN_W-1:0] plen;
  logic [LEN_W:0]   newlen;
  logic             err;
  logic [LEN_W-1:0] k;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    width  = cfg.family_is_v6 ? V6_WIDTH : V4_WIDTH;
    plen   = (cfg.base_prefix_len > width) ? width : cfg.base_prefix_len;
    newlen = {1'b0, plen} + {1'b0, in_data.extra_bits};
    err    = newlen > {1'b0, width};
    k      = width - newlen[LEN_W-1:0];

    q_data.fresh  = fresh_r;
    q_data.v6     = cfg.family_is_v6;
    q_data.err    = err;
    q_data.last   = in_data.last_in_list;
    q_data.newlen = newlen[LEN_W-1:0];
    q_data.start  = {cfg.base_addr_hi, cfg.base_addr_lo} & width_mask(cfg.family_is_v6)
                    & ~low_mask(width - plen);
    q_data.mask   = low_mask(k);
  end

  // A new list begins after every request marked last.
  assign fresh_nxt = q_push ? in_data.last_in_list : fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
    end else begin
      fresh_r <= fresh_nxt;
    end
  end

  a_v4_mask_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_data.err && !q_data.v6) |-> (q_data.mask[ADDR_W-1:V4_BITS] == '0))
    else $error("IPv4 alignment mask reaches above the address width");

endmodule

@@ hdl/csa_queue.sv @@
// ----------------------------------------------------------------------------
// csa_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module csa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  csa_pkg::csa_qent_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output csa_pkg::csa_qent_t head
);
  import csa_pkg::*;

  csa_qent_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QDEPTH)))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("pop from an empty queue");

endmodule

@@ hdl/csa_back.sv @@
// ----------------------------------------------------------------------------
// csa_back
// Holds the cursor, aligns it to each subnet boundary, advances it and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module csa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  csa_pkg::csa_qent_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output csa_pkg::csa_out_t  out_data
);
  import csa_pkg::*;

  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  csa_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0] wm;
  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] mask2;
  logic [ADDR_W-1:0] sum_round;
  logic [ADDR_W-1:0] sum_adv;
  logic [ADDR_W-1:0] rounded;
  logic [ADDR_W-1:0] advanced;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Rounding up and rounding up plus one subnet run as two parallel adds:
  // adding 2^(k+1)-1 instead of 2^k-1 sets the extra subnet in the same pass.
  always_comb begin
    wm        = width_mask(q_head.v6);
    cur       = q_head.fresh ? q_head.start : (cursor_r & wm);
    mask2     = {q_head.mask[ADDR_W-2:0], 1'b1};
    sum_round = cur + q_head.mask;
    sum_adv   = cur + mask2;
    rounded   = sum_round & ~q_head.mask & wm;
    advanced  = sum_adv & ~q_head.mask & wm;

    out_nxt.end_of_list = q_head.last;
    if (q_head.err) begin
      out_nxt.subnet_addr_hi    = '0;
      out_nxt.subnet_addr_lo    = '0;
      out_nxt.subnet_prefix_len = '0;
      out_nxt.status            = STATUS_NO_ROOM;
      cursor_nxt                = cur;
    end else begin
      out_nxt.subnet_addr_hi    = rounded[ADDR_W-1:HALF_W];
      out_nxt.subnet_addr_lo    = rounded[HALF_W-1:0];
      out_nxt.subnet_prefix_len = q_head.newlen;
      out_nxt.status            = STATUS_OK;
      cursor_nxt                = advanced;
    end

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cursor_r <= cursor_nxt;
      out_r    <= out_nxt;
    end
  end

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == STATUS_NO_ROOM)) |->
      (out_r.subnet_addr_hi == '0 && out_r.subnet_addr_lo == '0 &&
       out_r.subnet_prefix_len == '0))
    else $error("failed request carries a nonzero address or length");

  a_v4_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_head.v6) |-> (cursor_nxt[ADDR_W-1:V4_BITS] == '0))
    else $error("IPv4 cursor carried above bit 31");

endmodule

@@ hdl/cidr_subnet_allocator.sv @@
// ----------------------------------------------------------------------------
// cidr_subnet_allocator
// Hands out consecutive IPv4 or IPv6 subnets carved from a base prefix.
// ----------------------------------------------------------------------------
// Usage:
//   Program family, base address and base prefix length through the cfg_
//   write port while the block is idle. Each request on the in_ channel gives
//   the extra prefix bits of the next subnet; each produces exactly one
//   result on the out_ channel, with status set when the prefix would exceed
//   the address width. The request marked last in its list makes the next
//   request start again from the masked base.
//   A request waits in the queue, then its result in the output register. One
//   request per cycle is sustained while out_ready is high: the cursor update is a
//   single pass of two parallel 128-bit adds in the back end, which sets the rate.
//   A two-entry queue sits between the front end and the back end, and the
//   result sits in an output register, so requests are still taken while a
//   result waits; when the receiver stalls long enough the queue fills and
//   in_ready drops. Reset empties the queue and the output register, restores
//   the register defaults (IPv6, zero base) and starts a new list.
// ----------------------------------------------------------------------------
module cidr_subnet_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [csa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [csa_pkg::HALF_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  csa_pkg::csa_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output csa_pkg::csa_out_t               out_data
);
  import csa_pkg::*;

  csa_cfg_t  cfg_r, cfg_nxt;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  csa_qent_t q_in;
  csa_qent_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_FAMILY:   cfg_nxt.family_is_v6    = cfg_wdata[0];
        REG_BASE_HI:  cfg_nxt.base_addr_hi    = cfg_wdata;
        REG_BASE_LO:  cfg_nxt.base_addr_lo    = cfg_wdata;
        REG_BASE_LEN: cfg_nxt.base_prefix_len = cfg_wdata[LEN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.family_is_v6    <= 1'b1;
      cfg_r.base_addr_hi    <= '0;
      cfg_r.base_addr_lo    <= '0;
      cfg_r.base_prefix_len <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  csa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  csa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  csa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CIDR subnet allocator against a cycle-free model of its cursor.
// A short table of directed requests and register writes comes first, then
// phases of random requests, each under its own base prefix and family. Every
// result is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  import csa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYC    = 6;
  localparam int SETTLE_CYC   = 4;
  localparam int N_PHASE      = 10;
  localparam int PHASE_ITEMS  = 95;
  localparam int HOLD_PHASE   = 6;
  localparam int HOLD_CYC     = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_NS     = 2_000_000;

  // Any index past the last register must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(5);

  localparam csa_out_t NO_ROOM_RES  = '{64'h0, 64'h0, 8'd0, STATUS_NO_ROOM, 1'b0};
  localparam csa_out_t NO_ROOM_LAST = '{64'h0, 64'h0, 8'd0, STATUS_NO_ROOM, 1'b1};

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [HALF_W-1:0]    val;
    csa_in_t              req;
    bit                   typed;
    csa_out_t             want;
  } row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [HALF_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  csa_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  csa_out_t          out_data;

  int tx_idle_pct   = 25;
  int rx_idle_pct   = 57;
  int sink_hold     = 0;
  bit hold_off_go   = 1'b0;
  bit hold_off_done = 1'b0;
  int mismatch_cnt  = 0;

  // Register mirror and allocation state of the predictor.
  logic              reg_v6       = 1'b1;
  logic [HALF_W-1:0] reg_base_hi  = '0;
  logic [HALF_W-1:0] reg_base_lo  = '0;
  logic [LEN_W-1:0]  reg_base_len = '0;
  logic [ADDR_W-1:0] alloc_cursor = '0;
  logic              new_list     = 1'b1;

  csa_out_t subnet_q[$];

  row_t dir_tab [0:32] = '{
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b0}, 1'b1, '{64'h0, 64'h0, 8'd0, STATUS_OK, 1'b0}},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd255, 1'b0}, 1'b1, NO_ROOM_RES},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd129, 1'b0}, 1'b1, NO_ROOM_RES},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd128, 1'b1}, 1'b1,
      '{64'h0, 64'h0, 8'd128, STATUS_OK, 1'b1}},
    '{ROW_CFG, REG_FAMILY,   64'h0,                   '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_HI,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LO,  64'hDEAD_BEEF_0A00_00FF, '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LEN, 64'd24,                  '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd8,   1'b0}, 1'b1,
      '{64'h0, 64'h0A00_0000, 8'd32, STATUS_OK, 1'b0}},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd7,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd9,   1'b0}, 1'b1, NO_ROOM_RES},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b1}, 1'b0, '0},
    '{ROW_CFG, REG_SPARE,    64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LEN, 64'd200,                 '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd1,   1'b1}, 1'b1, NO_ROOM_LAST},
    '{ROW_CFG, REG_BASE_LEN, 64'd30,                  '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LO,  64'hFFFF_FFFC,           '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd1,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd1,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd1,   1'b1}, 1'b0, '0},
    '{ROW_CFG, REG_FAMILY,   64'h1,                   '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LO,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LEN, 64'd127,                 '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b0}, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd1,   1'b1}, 1'b0, '0},
    '{ROW_CFG, REG_BASE_HI,  64'h2001_0DB8_0000_0000, '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LEN, 64'd64,                  '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd32,  1'b0}, 1'b0, '0},
    // Family and base change in the middle of a list.
    '{ROW_CFG, REG_FAMILY,   64'h0,                   '0, 1'b0, '0},
    '{ROW_CFG, REG_BASE_LO,  64'h0,                   '0, 1'b0, '0},
    '{ROW_REQ, REG_FAMILY,   64'h0, '{8'd0,   1'b1}, 1'b0, '0}
  };

  cidr_subnet_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [ADDR_W-1:0] low_ones(input int k);
    return (k >= ADDR_W) ? '1 : ((ADDR_W'(1) << k) - ADDR_W'(1));
  endfunction

  function automatic logic [ADDR_W-1:0] pow2(input int k);
    return (k >= ADDR_W) ? '0 : (ADDR_W'(1) << k);
  endfunction

  // Works out the subnet for one request and moves the cursor past it.
  function automatic csa_out_t predict_subnet(input csa_in_t req);
    csa_out_t          res;
    int                fam_w, plen, nlen, k;
    logic [ADDR_W-1:0] wmask, m;
    fam_w = reg_v6 ? ADDR_W : V4_BITS;
    plen  = (reg_base_len > fam_w) ? fam_w : int'(reg_base_len);
    wmask = low_ones(fam_w);
    if (new_list)
      alloc_cursor = {reg_base_hi, reg_base_lo} & ~low_ones(fam_w - plen);
    alloc_cursor &= wmask;
    nlen = plen + int'(req.extra_bits);
    res = '0;
    res.end_of_list = req.last_in_list;
    if (nlen > fam_w) begin
      res.status = STATUS_NO_ROOM;
    end else begin
      k = fam_w - nlen;
      m = low_ones(k);
      // Round up to the next boundary of a subnet this size.
      if ((alloc_cursor & m) != '0)
        alloc_cursor = ((alloc_cursor & ~m) + pow2(k)) & wmask;
      {res.subnet_addr_hi, res.subnet_addr_lo} = alloc_cursor;
      res.subnet_prefix_len = LEN_W'(nlen);
      res.status = STATUS_OK;
      alloc_cursor = (alloc_cursor + pow2(k)) & wmask;
    end
    new_list = req.last_in_list;
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FAMILY:   reg_v6       = val[0];
      REG_BASE_HI:  reg_base_hi  = val;
      REG_BASE_LO:  reg_base_lo  = val;
      REG_BASE_LEN: reg_base_len = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Valid is left high after the transfer so back-to-back requests need no
  // extra assignment; it only drops on a sender gap or in wait_idle.
  task automatic send_req(input csa_in_t req, input bit typed, input csa_out_t typed_res);
    csa_out_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_subnet(req);
    subnet_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (subnet_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_sink
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (hold_off_go && !hold_off_done) begin
      out_ready     <= 1'b0;
      sink_hold     <= HOLD_CYC;
      hold_off_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    csa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (subnet_q.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t: result with no request outstanding: %h_%h /%0d status %0b eol %0b",
                   $realtime, out_data.subnet_addr_hi, out_data.subnet_addr_lo,
                   out_data.subnet_prefix_len, out_data.status, out_data.end_of_list);
        mismatch_cnt++;
      end else begin
        want = subnet_q.pop_front();
        if (out_data.subnet_addr_hi !== want.subnet_addr_hi ||
            out_data.subnet_addr_lo !== want.subnet_addr_lo ||
            out_data.subnet_prefix_len !== want.subnet_prefix_len ||
            out_data.status !== want.status ||
            out_data.end_of_list !== want.end_of_list) begin
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("%0t: expected %h_%h /%0d status %0b eol %0b", $realtime,
                     want.subnet_addr_hi, want.subnet_addr_lo, want.subnet_prefix_len,
                     want.status, want.end_of_list);
            $display("%0t:      got %h_%h /%0d status %0b eol %0b", $realtime,
                     out_data.subnet_addr_hi, out_data.subnet_addr_lo,
                     out_data.subnet_prefix_len, out_data.status, out_data.end_of_list);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int                fam_w, plen, room, roll;
    logic              fam;
    logic [HALF_W-1:0] b_hi, b_lo, rnd;
    logic [LEN_W-1:0]  b_len;
    csa_in_t           req;

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      wait_idle();
      b_hi = {$urandom, $urandom};
      b_lo = {$urandom, $urandom};
      case (ph)
        0: begin fam = 1'b0; b_len = 8'd0; end
        1: begin fam = 1'b1; b_hi = '1; b_lo = '1; b_len = 8'd128; end
        2: begin fam = 1'b0; b_len = 8'd255; end
        3: begin fam = 1'b1; b_hi = '0; b_lo = '0; b_len = 8'd0; end
        default: begin
          fam   = 1'($urandom_range(1));
          b_len = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(fam ? ADDR_W : V4_BITS));
        end
      endcase
      // Only the low bits of the family and length writes matter.
      rnd = {$urandom, $urandom};
      write_reg(REG_FAMILY, {rnd[HALF_W-1:1], fam});
      write_reg(REG_BASE_HI, b_hi);
      write_reg(REG_BASE_LO, b_lo);
      rnd = {$urandom, $urandom};
      write_reg(REG_BASE_LEN, {rnd[HALF_W-1:LEN_W], b_len});
      write_reg(CFG_IDX_W'($urandom_range(7, 4)), {$urandom, $urandom});

      if (ph < 3) begin
        tx_idle_pct <= 25;
        rx_idle_pct <= 57;
      end else if (ph < 6) begin
        tx_idle_pct <= 57;
        rx_idle_pct <= 25;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      if (ph == HOLD_PHASE) hold_off_go <= 1'b1;

      fam_w = reg_v6 ? ADDR_W : V4_BITS;
      plen  = (reg_base_len > fam_w) ? fam_w : int'(reg_base_len);
      room  = fam_w - plen;
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 70)
          req.extra_bits = 8'($urandom_range(room));
        else if (roll < 80 && room < 255)
          req.extra_bits = 8'($urandom_range(255, room + 1));
        else
          req.extra_bits = 8'($urandom_range(255));
        req.last_in_list = ($urandom_range(7) == 0);
        send_req(req, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ cidr_subnet_allocator.f @@
hdl/csa_pkg.sv
hdl/csa_front.sv
hdl/csa_queue.sv
hdl/csa_back.sv
hdl/cidr_subnet_allocator.sv
verif/testbench.sv
